>>> sv/iolh_pkg.sv
package iolh_pkg;

  // Command codes of an input transaction
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_ISSUE  = 2'd1;
  localparam logic [1:0] CMD_COMPL  = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_STARTED = 3'd0;
  localparam logic [2:0] ST_SKIPPED = 3'd1;
  localparam logic [2:0] ST_RECORD  = 3'd2;
  localparam logic [2:0] ST_NOSTART = 3'd3;
  localparam logic [2:0] ST_NEG     = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;
  localparam logic [2:0] ST_READ    = 3'd6;

  // Configuration register indexes
  localparam logic [2:0] CFG_PER_DISK    = 3'd0;
  localparam logic [2:0] CFG_PER_FLAG    = 3'd1;
  localparam logic [2:0] CFG_QUEUED_ONLY = 3'd2;
  localparam logic [2:0] CFG_UNIT_MS     = 3'd3;
  localparam logic [2:0] CFG_FILTER_EN   = 3'd4;
  localparam logic [2:0] CFG_TARGET_DEV  = 3'd5;

  // Nanosecond divisors for the two bucket units
  localparam logic [63:0] DIV_US = 64'd1000;
  localparam logic [63:0] DIV_MS = 64'd1000000;

endpackage

>>> sv/iolh_in_if.sv
interface iolh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [5:0]  request_tag;
  logic [63:0] timestamp;
  logic        has_scheduler;
  logic [31:0] device_number;
  logic [31:0] request_flags;
  logic [3:0]  read_key;
  logic [4:0]  read_slot;

  modport source (output valid, cmd, request_tag, timestamp, has_scheduler, device_number,
                  request_flags, read_key, read_slot, input ready);
  modport sink (input valid, cmd, request_tag, timestamp, has_scheduler, device_number,
                request_flags, read_key, read_slot, output ready);
endinterface

>>> sv/iolh_out_if.sv
interface iolh_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  key_index;
  logic [4:0]  slot;
  logic [31:0] count;

  modport source (output valid, status, key_index, slot, count, input ready);
  modport sink (input valid, status, key_index, slot, count, output ready);
endinterface

>>> sv/iolh_cfg_if.sv
interface iolh_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/iolh_ram.sv
module iolh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/io_latency_histogram_core.sv
// Request latency histogram. Insert and issue transactions store a start time per tag;
// a completion takes now minus start, scales it to us or ms, and bumps the floor-log2
// bucket of the histogram picked by the (device, flags) key. A read transaction returns
// one bucket count. One transaction is worked at a time and produces one result.
// Steps: an insert or issue checks the filters and writes its start time if they pass,
// then goes to the result stage. A read of an allocated bucket reads the bucket memory;
// a read that is out of range or hits an unallocated entry goes straight to the result
// stage. A completion reads and clears its start time, and stops there with no start or
// with a negative delta. Otherwise the key search reads the key memory one entry a cycle,
// running all KEYS entries when no entry matches, and the floor-log2 slot is found by a
// shift-and-compare step per cycle; a newly allocated histogram first clears its row in
// the bucket memory, then the bucket is read and incremented. A full key table drops the
// event. A result is held in the result stage while out_chan.ready stalls.
// After reset the start-time memory is cleared entry by entry, during which no
// transaction is taken; configuration writes are always taken and should only be
// issued while the block is idle.
module io_latency_histogram_core
  import iolh_pkg::*;
#(
  parameter int TAGS  = 64,
  parameter int KEYS  = 16,
  parameter int SLOTS = 27
) (
  input  logic            clk,
  input  logic            rst_n,
  iolh_in_if.sink         in_chan,
  iolh_out_if.source      out_chan,
  iolh_cfg_if.sink        cfg_chan
);

  localparam int TW  = (TAGS > 1) ? $clog2(TAGS) : 1;
  localparam int KW  = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int SLW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BD  = KEYS * SLOTS;
  localparam int BW  = (BD > 1) ? $clog2(BD) : 1;

  typedef enum logic [11:0] {
    S_CLRT  = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_START = 12'b000000000100,
    S_TRD   = 12'b000000001000,
    S_EVAL  = 12'b000000010000,
    S_SRCH  = 12'b000000100000,
    S_BCLR  = 12'b000001000000,
    S_LOG   = 12'b000010000000,
    S_BRD   = 12'b000100000000,
    S_BWR   = 12'b001000000000,
    S_PUT   = 12'b010000000000,
    S_SPARE = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [TW-1:0]   clr_cnt_r;
  logic            per_disk_r, per_flag_r, queued_only_r, unit_ms_r, filter_r;
  logic [31:0]     target_r;
  logic [1:0]      cmd_r;
  logic [TW-1:0]   tag_r;
  logic            tag_ok_r;
  logic [63:0]     ts_r;
  logic            sched_r;
  logic [31:0]     dev_r, flags_r;
  logic            is_rd_r;
  logic [63:0]     delta_r;
  logic [63:0]     key_val_r;
  logic [KW-1:0]   idx_r, idx_nxt;
  logic            free_ok_r;
  logic [KW-1:0]   free_idx_r;
  logic [KEYS-1:0] key_valid_r;
  logic [KW-1:0]   key_r;
  logic [SLW-1:0]  slot_r, cnt_r;
  logic [64:0]     thr_r;
  logic [2:0]      res_st_r;
  logic [3:0]      res_key_r;
  logic [4:0]      res_slot_r;
  logic [31:0]     res_cnt_r;
  logic            out_valid_r;
  logic [2:0]      out_st_r;
  logic [3:0]      out_key_r;
  logic [4:0]      out_slot_r;
  logic [31:0]     out_cnt_r;

  logic            acc_in, can_put;
  logic [TW-1:0]   in_tag_idx;
  logic            in_tag_ok;
  logic [KW-1:0]   in_key_idx;
  logic            in_rd_ok;
  logic            start_ok;
  logic            hit, last, free_now_ok;
  logic [KW-1:0]   free_now_idx;
  logic            log_more;
  logic [63:0]     div_val;

  logic            t_we;
  logic [TW-1:0]   t_wa;
  logic [64:0]     t_wd, t_rd;
  logic            k_we;
  logic [63:0]     k_rd;
  logic            b_we;
  logic [SLW-1:0]  b_off;
  logic [BW-1:0]   b_addr;
  logic [31:0]     b_wd, b_rd;

  // Start time memory: valid bit over the 64-bit timestamp
  iolh_ram #(.WIDTH(65), .DEPTH(TAGS)) u_tag_ram (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(in_tag_idx), .rdata(t_rd)
  );

  // Histogram key memory
  iolh_ram #(.WIDTH(64), .DEPTH(KEYS)) u_key_ram (
    .clk(clk), .we(k_we), .waddr(free_now_idx), .wdata(key_val_r), .raddr(idx_nxt),
    .rdata(k_rd)
  );

  // Bucket count memory, one row of SLOTS per key entry
  iolh_ram #(.WIDTH(32), .DEPTH(BD)) u_bkt_ram (
    .clk(clk), .we(b_we), .waddr(b_addr), .wdata(b_wd), .raddr(b_addr), .rdata(b_rd)
  );

  assign in_chan.ready  = (state_r == S_IDLE);
  assign acc_in         = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign can_put        = !out_valid_r || out_chan.ready;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = out_st_r;
  assign out_chan.key_index = out_key_r;
  assign out_chan.slot      = out_slot_r;
  assign out_chan.count     = out_cnt_r;

  // Decode the incoming transaction
  assign in_tag_idx = TW'(32'(in_chan.request_tag));
  assign in_tag_ok  = 32'(in_chan.request_tag) < 32'(TAGS);
  assign in_key_idx = KW'(32'(in_chan.read_key));
  assign in_rd_ok   = (32'(in_chan.read_key) < 32'(KEYS)) &&
                      (32'(in_chan.read_slot) < 32'(SLOTS)) && key_valid_r[in_key_idx];

  assign start_ok = tag_ok_r && !(cmd_r == CMD_ISSUE && queued_only_r && sched_r) &&
                    !(filter_r && target_r != dev_r);

  // Key search step
  assign hit          = key_valid_r[idx_r] && (k_rd == key_val_r);
  assign last         = (idx_r == KW'(KEYS - 1));
  assign free_now_ok  = free_ok_r || !key_valid_r[idx_r];
  assign free_now_idx = free_ok_r ? free_idx_r : idx_r;

  // Log2 step: delta compared against divisor shifted by slot+1
  assign div_val  = unit_ms_r ? DIV_MS : DIV_US;
  assign log_more = (slot_r != SLW'(SLOTS - 1)) && ({1'b0, delta_r} >= thr_r);

  always_comb begin
    idx_nxt = idx_r;
    if (state_r == S_EVAL) begin
      idx_nxt = '0;
    end else if (state_r == S_SRCH) begin
      idx_nxt = idx_r + KW'(1);
    end
  end

  // Memory write controls
  always_comb begin
    t_we = 1'b0;
    t_wa = tag_r;
    t_wd = {1'b1, ts_r};
    case (state_r)
      S_CLRT: begin
        t_we = 1'b1;
        t_wa = clr_cnt_r;
        t_wd = '0;
      end
      S_START: begin
        t_we = start_ok;
      end
      S_TRD: begin
        t_we = tag_ok_r && t_rd[64];
        t_wd = {1'b0, t_rd[63:0]};
      end
      default: begin
        t_we = 1'b0;
      end
    endcase
  end

  assign k_we   = (state_r == S_SRCH) && last && !hit && free_now_ok;
  assign b_off  = (state_r == S_BCLR) ? cnt_r : slot_r;
  assign b_addr = BW'(key_r) * BW'(SLOTS) + BW'(b_off);
  assign b_we   = (state_r == S_BCLR) || (state_r == S_BWR && !is_rd_r);
  assign b_wd   = (state_r == S_BCLR) ? 32'd0 : b_rd + 32'd1;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLRT: begin
        if (clr_cnt_r == TW'(TAGS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc_in) begin
          case (in_chan.cmd)
            CMD_INSERT, CMD_ISSUE: state_nxt = S_START;
            CMD_COMPL:             state_nxt = S_TRD;
            default:               state_nxt = in_rd_ok ? S_BRD : S_PUT;
          endcase
        end
      end
      S_START: state_nxt = S_PUT;
      S_TRD:   state_nxt = (tag_ok_r && t_rd[64]) ? S_EVAL : S_PUT;
      S_EVAL:  state_nxt = delta_r[63] ? S_PUT : S_SRCH;
      S_SRCH: begin
        if (hit) begin
          state_nxt = S_LOG;
        end else if (last) begin
          state_nxt = free_now_ok ? S_BCLR : S_PUT;
        end
      end
      S_BCLR: begin
        if (cnt_r == SLW'(SLOTS - 1)) state_nxt = S_LOG;
      end
      S_LOG: begin
        if (!log_more) state_nxt = S_BRD;
      end
      S_BRD: state_nxt = S_BWR;
      S_BWR: state_nxt = S_PUT;
      S_PUT: begin
        if (can_put) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLRT;
      clr_cnt_r     <= '0;
      key_valid_r   <= '0;
      out_valid_r   <= 1'b0;
      per_disk_r    <= 1'b0;
      per_flag_r    <= 1'b0;
      queued_only_r <= 1'b0;
      unit_ms_r     <= 1'b0;
      filter_r      <= 1'b0;
      target_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLRT) clr_cnt_r <= clr_cnt_r + TW'(1);
      if (k_we) key_valid_r[free_now_idx] <= 1'b1;
      if (state_r == S_PUT && can_put) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      // Take configuration writes
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          CFG_PER_DISK:    per_disk_r    <= cfg_chan.data[0];
          CFG_PER_FLAG:    per_flag_r    <= cfg_chan.data[0];
          CFG_QUEUED_ONLY: queued_only_r <= cfg_chan.data[0];
          CFG_UNIT_MS:     unit_ms_r     <= cfg_chan.data[0];
          CFG_FILTER_EN:   filter_r      <= cfg_chan.data[0];
          CFG_TARGET_DEV:  target_r      <= cfg_chan.data;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          cmd_r      <= in_chan.cmd;
          tag_r      <= in_tag_idx;
          tag_ok_r   <= in_tag_ok;
          ts_r       <= in_chan.timestamp;
          sched_r    <= in_chan.has_scheduler;
          dev_r      <= in_chan.device_number;
          flags_r    <= in_chan.request_flags;
          is_rd_r    <= (in_chan.cmd == CMD_READ);
          key_r      <= in_key_idx;
          slot_r     <= SLW'(32'(in_chan.read_slot));
          res_st_r   <= ST_READ;
          res_cnt_r  <= '0;
          res_key_r  <= (in_chan.cmd == CMD_READ) ? in_chan.read_key : 4'd0;
          res_slot_r <= (in_chan.cmd == CMD_READ) ? in_chan.read_slot : 5'd0;
        end
      end
      S_START: begin
        res_st_r <= start_ok ? ST_STARTED : ST_SKIPPED;
      end
      S_TRD: begin
        res_st_r <= ST_NOSTART;
        delta_r  <= ts_r - t_rd[63:0];
      end
      S_EVAL: begin
        res_st_r  <= ST_NEG;
        key_val_r <= {per_disk_r ? dev_r : 32'd0, per_flag_r ? flags_r : 32'd0};
        idx_r     <= idx_nxt;
        free_ok_r <= 1'b0;
        thr_r     <= {div_val, 1'b0};
        slot_r    <= '0;
      end
      S_SRCH: begin
        idx_r    <= idx_nxt;
        res_st_r <= ST_FULL;
        if (!free_ok_r && !key_valid_r[idx_r]) begin
          free_ok_r  <= 1'b1;
          free_idx_r <= idx_r;
        end
        if (hit) begin
          key_r <= idx_r;
        end else if (k_we) begin
          key_r <= free_now_idx;
          cnt_r <= '0;
        end
      end
      S_BCLR: begin
        cnt_r <= cnt_r + SLW'(1);
      end
      S_LOG: begin
        if (log_more) begin
          slot_r <= slot_r + SLW'(1);
          thr_r  <= {thr_r[63:0], 1'b0};
        end
      end
      S_BWR: begin
        if (is_rd_r) begin
          res_cnt_r <= b_rd;
        end else begin
          res_cnt_r  <= b_wd;
          res_st_r   <= ST_RECORD;
          res_key_r  <= 4'(32'(key_r));
          res_slot_r <= 5'(32'(slot_r));
        end
      end
      S_PUT: begin
        if (can_put) begin
          out_st_r   <= res_st_r;
          out_key_r  <= res_key_r;
          out_slot_r <= res_slot_r;
          out_cnt_r  <= res_cnt_r;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // An accepted transaction always leaves the idle state
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in |=> state_r != S_IDLE)
    else $error("accepted transaction did not start work");

  // Bucket memory is written only while clearing a row or updating a count
  a_bkt_we: assert property (@(posedge clk) disable iff (!rst_n)
    b_we |-> (state_r == S_BCLR || state_r == S_BWR))
    else $error("bucket write outside clear or update");

  // Allocation adds exactly one entry to the key table
  a_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    k_we |=> $countones(key_valid_r) == $past($countones(key_valid_r)) + 1)
    else $error("key allocation reused a live entry");

  // The log2 slot stays inside the histogram row
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOG || state_r == S_BWR) |-> 32'(slot_r) < 32'(SLOTS))
    else $error("slot beyond histogram row");

  // A result is handed over only from the result stage
  a_put: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_PUT)
    else $error("result raised outside result stage");
`endif

endmodule
